// File: hw/rtl/clws_pkg.sv
// Shared types, codes and helpers for the character LCD write sequencer.
package clws_pkg;

	typedef enum logic [1:0] {
		KIND_CMD    = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_CURSOR = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	localparam int CFG_INDEX_W = 2;
	localparam int HOLD_W      = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FOUR_BIT = 2'd0,
		CFG_HOLD     = 2'd1,
		CFG_SPARE2   = 2'd2,
		CFG_SPARE3   = 2'd3
	} cfg_index_t;

	localparam logic              FOUR_BIT_RESET   = 1'b1;
	localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET = 16'd16000;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
	localparam logic [7:0] HI_NIBBLE     = 8'hF0;
	localparam logic [7:0] LO_NIBBLE     = 8'h0F;

	// Phase numbers within one write
	localparam int         PHASE_W     = 3;
	localparam logic [2:0] PH_SETUP    = 3'd0;
	localparam logic [2:0] PH_DRIVE_HI = 3'd2;
	localparam logic [2:0] PH_LAST_8   = 3'd3;
	localparam logic [2:0] PH_DRIVE_LO = 3'd5;
	localparam logic [2:0] PH_LAST_4   = 3'd6;

	// One display write, as it travels through the queue
	typedef struct packed {
		logic       rs;
		logic [7:0] data_byte;
	} wr_t;

	typedef struct packed {
		logic              nibble_mode;
		logic [HOLD_W-1:0] hold_ticks;
	} cfg_t;

	function automatic logic [7:0] cursor_cmd(input logic [1:0] row, input logic [3:0] col);
		logic [7:0] base;
		logic [7:0] addr;
		unique case (row)
			2'd0: base = 8'h00;
			2'd1: base = 8'h40;
			2'd2: base = 8'h10;
			default: base = 8'h50;
		endcase
		addr = base + {4'd0, col};
		return SET_DDRAM_CMD | {1'b0, addr[6:0]};
	endfunction

endpackage

// File: hw/rtl/clws_if.sv
// Channel interfaces: write requests, pin phases and configuration writes.
interface clws_cmd_if;
	import clws_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic [1:0] row;
	logic [3:0] col;
	modport source (output valid, kind, value, row, col, input ready);
	modport sink   (input valid, kind, value, row, col, output ready);
endinterface

interface clws_pin_if;
	import clws_pkg::*;
	logic       valid;
	logic       ready;
	logic       reg_select;
	logic       enable;
	logic [7:0] bus;
	logic       last;
	modport source (output valid, reg_select, enable, bus, last, input ready);
	modport sink   (input valid, reg_select, enable, bus, last, output ready);
endinterface

interface clws_cfg_if;
	import clws_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [HOLD_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/clws_front.sv
// Front end: accepts write requests, drops unused kinds, forms the byte and RS.
module clws_front (
	input  logic          clk,
	input  logic          arst_n,
	clws_cmd_if.sink      cmd,
	output logic          push_valid,
	input  logic          push_ready,
	output clws_pkg::wr_t push_data
);
	import clws_pkg::*;

	logic valid_s1;
	wr_t  wr_s1;
	wr_t  wr_d;
	logic keep;

	assign cmd.ready = !valid_s1 || push_ready;

	always_comb begin
		wr_d = '0;
		keep = 1'b1;
		unique case (kind_t'(cmd.kind))
			KIND_CMD: begin
				wr_d.rs        = 1'b0;
				wr_d.data_byte = cmd.value;
			end
			KIND_DATA: begin
				wr_d.rs        = 1'b1;
				wr_d.data_byte = cmd.value;
			end
			KIND_CURSOR: begin
				wr_d.rs        = 1'b0;
				wr_d.data_byte = cursor_cmd(cmd.row, cmd.col);
			end
			default: keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			wr_s1 <= wr_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = wr_s1;

endmodule

// File: hw/rtl/clws_queue.sv
// Small FIFO between the front end and the pin sequencer.
module clws_queue #(
	parameter int DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  clws_pkg::wr_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output clws_pkg::wr_t pop_data
);
	import clws_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	wr_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_FULL;
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hw/rtl/clws_back.sv
// Pin sequencer: steps each write through its RS/E/bus phases with hold timing.
module clws_back (
	input  logic           clk,
	input  logic           arst_n,
	input  clws_pkg::cfg_t cfg,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  clws_pkg::wr_t  pop_data,
	clws_pin_if.source     pins
);
	import clws_pkg::*;

	logic               active_q;
	wr_t                cur_q;
	logic [PHASE_W-1:0] phase_q;
	logic [7:0]         bus_hold_q;
	logic [HOLD_W-1:0]  wait_q;

	logic               out_valid_q;
	logic               rs_q;
	logic               enable_q;
	logic [7:0]         bus_q;
	logic               last_q;

	wr_t                cur;
	logic [PHASE_W-1:0] phase;
	logic               have;
	logic               out_free;
	logic               issue;
	logic               is_drive;
	logic [7:0]         drive_val;
	logic [7:0]         bus_d;
	logic               enable_d;
	logic               last_d;

	assign cur      = active_q ? cur_q : pop_data;
	assign phase    = active_q ? phase_q : PH_SETUP;
	assign have     = active_q || pop_valid;
	assign out_free = !out_valid_q || pins.ready;
	assign issue    = have && out_free && (wait_q == '0);
	assign pop_ready = issue && !active_q;

	// Drive phases load the bus; all other phases replay the held value
	always_comb begin
		is_drive  = 1'b0;
		drive_val = cur.data_byte;
		if (cfg.nibble_mode) begin
			if (phase == PH_DRIVE_HI) begin
				is_drive  = 1'b1;
				drive_val = cur.data_byte & HI_NIBBLE;
			end else if (phase == PH_DRIVE_LO) begin
				is_drive  = 1'b1;
				drive_val = (cur.data_byte & LO_NIBBLE) << 4;
			end
			last_d = phase == PH_LAST_4;
		end else begin
			is_drive = phase == PH_DRIVE_HI;
			last_d   = phase == PH_LAST_8;
		end
		bus_d = is_drive ? drive_val : bus_hold_q;
		// E is low on setup and on every phase after a drive
		enable_d = !(phase == PH_SETUP || phase == PH_LAST_8 || last_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			phase_q     <= PH_SETUP;
			bus_hold_q  <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				active_q    <= !last_d;
				phase_q     <= phase + 1'b1;
				bus_hold_q  <= bus_d;
				wait_q      <= (cfg.hold_ticks == '0) ? '0 : cfg.hold_ticks - 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				if (wait_q != '0) begin
					wait_q <= wait_q - 1'b1;
				end
				if (pins.ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			if (!active_q) begin
				cur_q <= pop_data;
			end
			rs_q     <= cur.rs;
			enable_q <= enable_d;
			bus_q    <= bus_d;
			last_q   <= last_d;
		end
	end

	assign pins.valid      = out_valid_q;
	assign pins.reg_select = rs_q;
	assign pins.enable     = enable_q;
	assign pins.bus        = bus_q;
	assign pins.last       = last_q;

endmodule

// File: hw/rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer: turns display writes into parallel pin phases.
//
// Channels: cmd takes one write per transaction (kind: command, data or
// cursor position with row/col). pins gives one transaction per pin phase:
// setup RS with E low, raise E, drive the bus, drop E; in four-bit mode the
// E/bus/E triple runs for the high then the low nibble (7 phases), else once
// (4 phases). last marks the final phase of a write. Kind 3 is dropped.
// cfg writes register 0 (nibble mode) or 1 (hold_ticks); it is always ready.
// The first phase of a write passes through the front-end register, the write
// queue and the sequencer's output register. Phases are spaced by the hold
// counter in the sequencer, which reloads from hold_ticks at each phase.
// A write queue lets cmd keep taking items while phases drain.
// Reset: queue empty, held bus value zero, nibble mode 1, hold_ticks 16000.
// A stalled pins receiver holds the current phase; the hold timer keeps
// running, and the next phase follows once the current one is taken and the
// timer has run out. Nothing is dropped.
module char_lcd_write_sequencer #(
	parameter int QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	clws_cmd_if.sink   cmd,
	clws_pin_if.source pins,
	clws_cfg_if.sink   cfg
);
	import clws_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	wr_t  push_data;
	logic pop_valid;
	logic pop_ready;
	wr_t  pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nibble_mode <= FOUR_BIT_RESET;
			cfg_q.hold_ticks  <= HOLD_TICKS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_FOUR_BIT: cfg_q.nibble_mode <= cfg.data[0];
				CFG_HOLD:     cfg_q.hold_ticks  <= cfg.data;
				default: ;
			endcase
		end
	end

	clws_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	clws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	clws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.pins      (pins)
	);

endmodule
